// ===== rtl/esort_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esort_pkg: shared types and constants of the exchange sort engine
// Store geometry, controller state encoding and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package esort_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_START,
      ST_LOAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic collect;
      logic start;
      logic load;
      logic scan;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last_accept;
      logic j_at_end;
      logic i_last;
      logic out_free;
   } status_type;

endpackage : esort_pkg
`default_nettype wire

// ===== rtl/esort_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esort_req_if / esort_rsp_if: handshake channels of the exchange sort engine
// Each channel carries valid, ready and the item fields; an item moves at a
// rising clock edge at which valid and ready are both high.
// ----------------------------------------------------------------------------
interface esort_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] item_value;
   logic               last_item;

   modport source (output valid, output item_value, output last_item, input ready);
   modport sink   (input valid, input item_value, input last_item, output ready);
endinterface : esort_req_if

interface esort_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sorted_value;
   logic               run_end;
   logic               overflowed;

   modport source (output valid, output sorted_value, output run_end,
                   output overflowed, input ready);
   modport sink   (input valid, input sorted_value, input run_end,
                   input overflowed, output ready);
endinterface : esort_rsp_if
`default_nettype wire

// ===== rtl/esort_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esort_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module esort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                           clock,
   input  wire logic                                           wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                               wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                               rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule : esort_ram
`default_nettype wire

// ===== rtl/esort_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esort_ctrl: sequencer of the exchange sort engine
// Steps through collection, a scan pass for each position with a later element
// and the emission of each position's final value.
// ----------------------------------------------------------------------------
module esort_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire esort_pkg::status_type  status,
   output esort_pkg::cmd_type          cmd
);
   import esort_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_COLLECT: begin
            cmd.collect = 1'b1;
            if (status.last_accept) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            // A position with no later element goes straight out.
            state_in = status.j_at_end ? ST_EMIT : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.j_at_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.i_last ? ST_COLLECT : ST_LOAD;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

endmodule : esort_ctrl
`default_nettype wire

// ===== rtl/esort_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esort_dp: datapath of the exchange sort engine
// Element RAM, fill count, overflow flag, pass indexes, the running value of
// the current position and the output register.
// ----------------------------------------------------------------------------
module esort_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire esort_pkg::cmd_type    cmd,
   output esort_pkg::status_type      status,
   esort_req_if.sink                  req_chan,
   esort_rsp_if.source                rsp_chan
);
   import esort_pkg::*;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic [ADDR_W-1:0]        i_ff, i_in;
   logic [CNT_W-1:0]         j_ff, j_in;
   logic signed [DATA_W-1:0] cur_ff, cur_in;

   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_value_ff, out_value_in;
   logic                     out_end_ff, out_end_in;
   logic                     out_ovf_ff, out_ovf_in;

   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic [ADDR_W-1:0]        rd_addr;
   logic [DATA_W-1:0]        rd_data;
   logic signed [DATA_W-1:0] rd_value;

   logic                     accept;
   logic [CNT_W-1:0]         j_prev;
   logic [ADDR_W-1:0]        i_next;

   esort_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   assign rd_value = $signed(rd_data);
   assign accept   = req_chan.valid && cmd.collect;
   assign j_prev   = j_ff - CNT_W'(1);
   assign i_next   = i_ff + ADDR_W'(1);

   assign req_chan.ready        = cmd.collect;
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.sorted_value = out_value_ff;
   assign rsp_chan.run_end      = out_end_ff;
   assign rsp_chan.overflowed   = out_ovf_ff;

   assign status.last_accept = accept && req_chan.last_item;
   assign status.j_at_end    = (j_ff == count_ff);
   assign status.i_last      = ((CNT_W'(i_ff) + CNT_W'(1)) == count_ff);
   assign status.out_free    = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_value_in = out_value_ff;
      out_end_in   = out_end_ff;
      out_ovf_in   = out_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = req_chan.item_value;
      rd_addr      = j_ff[ADDR_W-1:0];

      if (accept) begin
         if (count_ff < CNT_W'(STORE_DEPTH)) begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.start) begin
         rd_addr = '0;
         i_in    = '0;
         j_in    = CNT_W'(1);
      end

      if (cmd.load) begin
         cur_in = rd_value;
         j_in   = j_ff + CNT_W'(1);
      end

      if (cmd.scan) begin
         // The later element is smaller: it takes the current position and
         // the old value moves down to where it came from.
         if (rd_value < cur_ff) begin
            wr_en   = 1'b1;
            wr_addr = j_prev[ADDR_W-1:0];
            wr_data = cur_ff;
            cur_in  = rd_value;
         end
         j_in = j_ff + CNT_W'(1);
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_value_in = cur_ff;
         out_end_in   = status.i_last;
         out_ovf_in   = ovf_ff;
         if (status.i_last) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            i_in    = i_next;
            rd_addr = i_next;
            j_in    = CNT_W'(i_ff) + CNT_W'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      cur_ff       <= cur_in;
      out_value_ff <= out_value_in;
      out_end_ff   <= out_end_in;
      out_ovf_ff   <= out_ovf_in;
   end

endmodule : esort_dp
`default_nettype wire

// ===== rtl/exchange_sort_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// exchange_sort_engine: collects a set of signed integers and returns it sorted
// Items arrive on req_chan, one signed 32-bit value per item; the item with
// last_item set closes the set. Up to 64 values are stored; items that arrive
// while the store is full are dropped, and every result of that run then
// carries overflowed. The sorted run leaves on rsp_chan in ascending order,
// with run_end on its final, largest item.
// The block takes input items only while it is collecting: one item a cycle.
// Once the last item is in, it sorts position by position: each position
// fetches its value and then compares it with every later element, one
// compare per cycle, since the element RAM gives one read a cycle.
// Each position's result is issued as soon as its pass ends; if the receiver
// stalls, the result waits in the output register and the next pass runs
// but holds before it issues its own result.
// Input is taken again after the final result of the run has been issued,
// even while that result still waits to be taken.
// A synchronous reset empties the set and clears the overflow flag and any
// pending result; stored values are not cleared.
// ----------------------------------------------------------------------------
module exchange_sort_engine (
   input  wire logic    clock,
   input  wire logic    reset,
   esort_req_if.sink    req_chan,
   esort_rsp_if.source  rsp_chan
);
   import esort_pkg::*;

   // Commands from the sequencer and status back from the datapath.
   cmd_type    cmd;
   status_type status;

   esort_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   esort_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule : exchange_sort_engine
`default_nettype wire

// ===== dv/sorted_run_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_run_checker: scoreboard for the exchange sort engine
// Watches both channels. It keeps its own copy of the open set, sorts the set
// when the closing item is taken, and compares every result item, field by
// field, with the oldest sorted value still awaited.
// ----------------------------------------------------------------------------
module sorted_run_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [esort_pkg::DATA_W-1:0]   req_item_value,
   input  logic                                  req_last_item,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [esort_pkg::DATA_W-1:0]   rsp_sorted_value,
   input  logic                                  rsp_run_end,
   input  logic                                  rsp_overflowed,
   output int                                    mismatch_count,
   output int                                    awaited_results
);

   typedef struct packed {
      logic signed [esort_pkg::DATA_W-1:0] sorted_value;
      logic                                run_end;
      logic                                overflowed;
   } sorted_entry_type;

   logic signed [esort_pkg::DATA_W-1:0] open_set [esort_pkg::STORE_DEPTH];
   int                                  open_count;
   logic                                open_overflow;
   sorted_entry_type                    awaited_q [$];

   task automatic take_value(input logic signed [esort_pkg::DATA_W-1:0] value,
                             input logic last);
      sorted_entry_type                    entry;
      logic signed [esort_pkg::DATA_W-1:0] swap;
      int                                  i;
      int                                  j;
      if (open_count < esort_pkg::STORE_DEPTH) begin
         open_set[open_count] = value;
         open_count++;
      end else begin
         open_overflow = 1'b1;
      end
      if (last) begin
         // Each position against every later one; strict compare, so equal
         // values stay where they are.
         for (i = 0; i < open_count; i++) begin
            for (j = i + 1; j < open_count; j++) begin
               if (open_set[j] < open_set[i]) begin
                  swap        = open_set[i];
                  open_set[i] = open_set[j];
                  open_set[j] = swap;
               end
            end
         end
         for (i = 0; i < open_count; i++) begin
            entry.sorted_value = open_set[i];
            entry.run_end      = (i == open_count - 1);
            entry.overflowed   = open_overflow;
            awaited_q.push_back(entry);
         end
         open_count    = 0;
         open_overflow = 1'b0;
      end
   endtask

   task automatic compare_result(input logic signed [esort_pkg::DATA_W-1:0] value,
                                 input logic run_end, input logic overflowed);
      sorted_entry_type want;
      if (awaited_q.size() == 0) begin
         $error("result item with none awaited: sorted_value %0d run_end %0b overflowed %0b",
                value, run_end, overflowed);
         mismatch_count++;
      end else begin
         want = awaited_q.pop_front();
         if (value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, actual %0d", want.sorted_value, value);
            mismatch_count++;
         end
         if (run_end !== want.run_end) begin
            $error("run_end: expected %0b, actual %0b", want.run_end, run_end);
            mismatch_count++;
         end
         if (overflowed !== want.overflowed) begin
            $error("overflowed: expected %0b, actual %0b", want.overflowed, overflowed);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         open_count     = 0;
         open_overflow  = 1'b0;
         mismatch_count = 0;
         awaited_q.delete();
      end else begin
         // Results of an earlier run are checked before a closing item of
         // the same edge adds a new run behind them.
         if (rsp_valid && rsp_ready)
            compare_result(rsp_sorted_value, rsp_run_end, rsp_overflowed);
         if (req_valid && req_ready)
            take_value(req_item_value, req_last_item);
      end
      awaited_results = awaited_q.size();
   end

endmodule : sorted_run_checker

// ===== dv/exchange_sort_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exchange_sort_engine_tb: top level of the exchange sort engine testbench
// Sends sets of signed values, small and large, full and overflowing, with
// random gaps on the input and random stalls on the output, and lets the
// scoreboard beside the engine check every sorted item as it leaves.
// ----------------------------------------------------------------------------
module exchange_sort_engine_tb;

   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam int RANDOM_ITEMS     = 80;
   // The final stretch of random items runs without any gaps or stalls.
   localparam int CALM_FROM        = 40;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES    = 100;

   logic clock = 1'b0;
   logic reset;

   // Set by the sender and read by the receiver process.
   logic calm;
   int   long_hold_cycles;

   int   mismatch_count;
   int   awaited_results;

   esort_req_if req_chan ();
   esort_rsp_if rsp_chan ();

   exchange_sort_engine dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sorted_run_checker run_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_item_value   (req_chan.item_value),
      .req_last_item    (req_chan.last_item),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_sorted_value (rsp_chan.sorted_value),
      .rsp_run_end      (rsp_chan.run_end),
      .rsp_overflowed   (rsp_chan.overflowed),
      .mismatch_count   (mismatch_count),
      .awaited_results  (awaited_results)
   );

   always #10 clock = ~clock;

   // Reset is held at the start and never asserted again.
   initial begin
      reset = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
   end

   // Upper bound on the whole run. The slowest correct run, with every set
   // at full depth, every gap and every stall at its longest, stays well
   // inside a tenth of this.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // A value for one item. Full random words make every bit toggle, a narrow
   // band around zero gives plenty of equal values, and the values near the
   // two ends of the range test the signed compare.
   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] value;
      case ($urandom_range(0, 5))
         0, 1:    value = $urandom;
         2:       value = $signed($urandom_range(0, 16)) - 8;
         3:       value = VALUE_MIN + $urandom_range(0, 3);
         4:       value = VALUE_MAX - $urandom_range(0, 3);
         default: value = $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      endcase
      return value;
   endfunction

   // Offers one item from a falling edge and holds it until the engine takes
   // it; returns at the falling edge after the handshake, so the caller
   // either drives the next item or drops valid there.
   task automatic send_item(input logic signed [31:0] value, input logic last);
      req_chan.valid      <= 1'b1;
      req_chan.item_value <= value;
      req_chan.last_item  <= last;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Sender gap. The payload carries noise while valid is low.
   task automatic sender_gap(input int cycles);
      req_chan.valid      <= 1'b0;
      req_chan.item_value <= $urandom;
      req_chan.last_item  <= $urandom_range(0, 1);
      repeat (cycles) @(negedge clock);
   endtask

   // Sends a set of the given size with random content; the item flagged as
   // last is the final one. Outside the calm stretch, gaps fall at random
   // between items, so they land on every phase of the collection.
   task automatic send_set(input int size);
      int k;
      for (k = 0; k < size; k++) begin
         send_item(pick_value(), k == size - 1);
         if (!calm && $urandom_range(0, 3) == 0)
            sender_gap($urandom_range(1, 14));
      end
   endtask

   // The sender stands still until every awaited result has left the engine.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (awaited_results != 0)
         @(negedge clock);
   endtask

   // Receiver: ready changes only at falling edges. It alternates stretches
   // of readiness with stall bursts, and honours one request for a long
   // hold-off, counted here in cycles, while the sender keeps offering items.
   initial begin : receiver
      int   cycles;
      logic hold_served;
      rsp_chan.ready = 1'b0;
      hold_served    = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (long_hold_cycles > 0 && !hold_served) begin
            cycles          = long_hold_cycles;
            hold_served     = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (cycles) @(negedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int sent;
      int size;
      req_chan.valid      = 1'b0;
      req_chan.item_value = '0;
      req_chan.last_item  = 1'b0;
      calm                = 1'b0;
      long_hold_cycles    = 0;
      do @(negedge clock); while (reset);

      // Directed part. A set of one item, the smallest value on its own.
      send_item(VALUE_MIN, 1'b1);
      // Both extremes, zero, minus one, one and two alternating bit patterns.
      send_item(VALUE_MAX, 1'b0);
      send_item(VALUE_MIN, 1'b0);
      send_item(32'sd0, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sd1, 1'b0);
      send_item(32'sh5555_5555, 1'b0);
      send_item(32'shAAAA_AAAA, 1'b1);
      // Repeated values: the strict compare must leave equal values alone.
      send_item(32'sd7, 1'b0);
      send_item(-32'sd2, 1'b0);
      send_item(32'sd7, 1'b0);
      send_item(32'sd7, 1'b0);
      send_item(-32'sd2, 1'b1);
      // A set already in order, then one in reverse order.
      send_item(-32'sd3, 1'b0);
      send_item(-32'sd2, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sd0, 1'b1);
      send_item(32'sd4, 1'b0);
      send_item(32'sd3, 1'b0);
      send_item(32'sd2, 1'b0);
      send_item(32'sd1, 1'b1);
      wait_drained();

      // Back pressure. The receiver holds off for a long stretch while a full
      // set, a set whose closing item finds the store full and is dropped,
      // and a small set are offered, so the engine stalls its input.
      long_hold_cycles = LONG_HOLD_CYCLES;
      send_set(esort_pkg::STORE_DEPTH);
      send_set(esort_pkg::STORE_DEPTH + 1);
      send_set(3);
      wait_drained();
      // A set that overruns the store by several items.
      send_set(esort_pkg::STORE_DEPTH + 6);
      wait_drained();

      // Random part: mostly small sets, some large, a few that overflow.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         calm = (sent >= CALM_FROM);
         case ($urandom_range(0, 39))
            0:       size = $urandom_range(esort_pkg::STORE_DEPTH + 1,
                                           esort_pkg::STORE_DEPTH + 8);
            1, 2, 3: size = $urandom_range(13, esort_pkg::STORE_DEPTH);
            default: size = $urandom_range(1, 12);
         endcase
         send_set(size);
         sent += size;
         if (!calm && $urandom_range(0, 9) == 0)
            wait_drained();
      end

      // Every set has been closed; wait for the last results, then watch the
      // output a while longer for anything that was not asked for.
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule : exchange_sort_engine_tb
